// ----- rtl/core/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types for the ray / box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int EPS_WIDTH       = 16;
	localparam int IDX_WIDTH       = 3;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5,
		REG_EPS   = 3'd6
	} cfg_reg_t;

	// per-axis status handed from an axis lane to the combine stage
	typedef struct packed {
		logic valid;
		logic par;
		logic in_slab;
	} rbst_axis_flags_t;

endpackage

// ----- rtl/core/ray_box_slab_test_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray against axis-aligned box slab test; box and epsilon in config registers.
// ----------------------------------------------------------------------------
// Path from ray beat to hit beat: axis prep register, dividers, key and order registers, output.
// Throughput: one ray per cycle unless stalled; the per-axis dividers retire one
// quotient bit per stage, so their depth (COORD_WIDTH + 1 stages) sets the latency.
// A stall on the hit side holds the whole pipeline in place.
// Reset clears all valid bits and sets every box bound and epsilon to zero.
module ray_box_slab_test_top
	import rbst_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ray_valid,
	output logic                          ray_stall,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                          hit_valid,
	input  logic                          hit_stall,
	output logic                          hit,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [IDX_WIDTH-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0]  box_min_q [0:2];
	logic signed [W-1:0]  box_max_q [0:2];
	logic [EPS_WIDTH-1:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
			eps_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_X: box_min_q[0] <= cfg_data;
				REG_MIN_Y: box_min_q[1] <= cfg_data;
				REG_MIN_Z: box_min_q[2] <= cfg_data;
				REG_MAX_X: box_max_q[0] <= cfg_data;
				REG_MAX_Y: box_max_q[1] <= cfg_data;
				REG_MAX_Z: box_max_q[2] <= cfg_data;
				REG_EPS:   eps_q        <= cfg_data[EPS_WIDTH-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	logic en;
	logic hit_valid_q, hit_q;

	// advance whenever the output register is free or being drained
	assign en        = !hit_valid_q || !hit_stall;
	assign ray_stall = !en;

	rbst_axis_flags_t fx, fy, fz;
	logic [W-1:0]     nx, ny, nz, fkx, fky, fkz;

	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_x (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.origin (origin_x), .dir (dir_x), .box_lo (box_min_q[0]), .box_hi (box_max_q[0]),
		.eps (eps_q), .flags (fx), .near_key (nx), .far_key (fkx)
	);

	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_y (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.origin (origin_y), .dir (dir_y), .box_lo (box_min_q[1]), .box_hi (box_max_q[1]),
		.eps (eps_q), .flags (fy), .near_key (ny), .far_key (fky)
	);

	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_z (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.origin (origin_z), .dir (dir_z), .box_lo (box_min_q[2]), .box_hi (box_max_q[2]),
		.eps (eps_q), .flags (fz), .near_key (nz), .far_key (fkz)
	);

	logic         ok_c, hit_c;
	logic [W-1:0] near_xy, far_xy, near_c, far_c;

	// a parallel axis with the origin outside its slab is a miss
	assign ok_c    = (!fx.par || fx.in_slab) && (!fy.par || fy.in_slab)
		&& (!fz.par || fz.in_slab);
	assign near_xy = (nx > ny) ? nx : ny;
	assign far_xy  = (fkx < fky) ? fkx : fky;
	assign near_c  = (near_xy > nz) ? near_xy : nz;
	assign far_c   = (far_xy < fkz) ? far_xy : fkz;
	assign hit_c   = ok_c && (far_c >= near_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else if (en) begin
			hit_valid_q <= fx.valid && fy.valid && fz.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_c;
		end
	end

	assign hit_valid = hit_valid_q;
	assign hit       = hit_q;

endmodule

// ----- rtl/core/rbst_div.sv -----
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider: floor((mag << F) / dmag), one quotient bit
// per stage, with an overflow flag when the quotient needs more than W+1 bits.
// ----------------------------------------------------------------------------
module rbst_div
	import rbst_pkg::*;
#(
	parameter int W = COORD_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] mag,
	input  logic [W-1:0] dmag,
	output logic [W:0]   quo,
	output logic         ovf
);

	localparam int QB = W + 1;
	localparam int NW = W + F;
	localparam int CW = (F - 1 > W) ? F - 1 : W;

	logic [NW-1:0] num;
	logic [F-2:0]  top_bits;
	logic          ovf0;

	logic [W-1:0]  rem_s  [0:QB];
	logic [QB-1:0] qn_s   [0:QB];
	logic          ovf_s  [0:QB];
	logic [W-1:0]  dmag_s [0:QB];

	assign num      = {mag, {F{1'b0}}};
	assign top_bits = num[NW-1:QB];
	// quotient would not fit in QB bits
	assign ovf0     = CW'(top_bits) >= CW'(dmag);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= W'(top_bits);
			qn_s[0]   <= num[QB-1:0];
			ovf_s[0]  <= ovf0;
			dmag_s[0] <= dmag;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		logic [W:0] shifted;
		logic [W:0] diff;
		logic       ge;

		assign shifted = {rem_s[j-1], qn_s[j-1][QB-1]};
		assign diff    = shifted - {1'b0, dmag_s[j-1]};
		assign ge      = shifted >= {1'b0, dmag_s[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[W-1:0] : shifted[W-1:0];
				qn_s[j]   <= {qn_s[j-1][QB-2:0], ge};
				ovf_s[j]  <= ovf_s[j-1];
				dmag_s[j] <= dmag_s[j-1];
			end
		end
	end

	assign quo = qn_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// ----- rtl/core/rbst_axis.sv -----
// ----------------------------------------------------------------------------
// rbst_axis
// One slab lane: parallel/inside test, two slab distances through pipelined
// dividers, saturation to the coordinate range, and ordering into near/far.
// ----------------------------------------------------------------------------
module rbst_axis
	import rbst_pkg::*;
#(
	parameter int W = COORD_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  origin,
	input  logic signed [W-1:0]  dir,
	input  logic signed [W-1:0]  box_lo,
	input  logic signed [W-1:0]  box_hi,
	input  logic [EPS_WIDTH-1:0] eps,
	output rbst_axis_flags_t     flags,
	output logic [W-1:0]         near_key,
	output logic [W-1:0]         far_key
);

	localparam int QB = W + 1;
	localparam logic [W:0]   LIM_POS  = {2'b00, {(W-1){1'b1}}};
	localparam logic [W:0]   LIM_NEG  = {2'b01, {(W-1){1'b0}}};
	localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic par;
		logic in_slab;
		logic neg_lo;
		logic neg_hi;
	} side_t;

	// saturate, apply sign, map to an order-preserving unsigned key
	function automatic logic [W-1:0] to_key(input logic [W:0] q, input logic ovf,
		input logic neg);
		logic [W:0] lim;
		logic [W:0] qm;
		logic [W:0] val;
		lim = neg ? LIM_NEG : LIM_POS;
		qm  = (ovf || q > lim) ? lim : q;
		val = neg ? (~qm + 1'b1) : qm;
		return val[W-1:0] ^ SIGN_BIT;
	endfunction

	// prep
	logic         dneg;
	logic [W-1:0] dmag_c;
	logic [W:0]   diff_lo, diff_hi, abs_lo, abs_hi;

	assign dneg    = dir[W-1];
	assign dmag_c  = dneg ? (~dir + 1'b1) : dir;
	assign diff_lo = {box_lo[W-1], box_lo} - {origin[W-1], origin};
	assign diff_hi = {box_hi[W-1], box_hi} - {origin[W-1], origin};
	assign abs_lo  = diff_lo[W] ? (~diff_lo + 1'b1) : diff_lo;
	assign abs_hi  = diff_hi[W] ? (~diff_hi + 1'b1) : diff_hi;

	logic         valid_s1;
	side_t        side_s1;
	logic [W-1:0] mag_lo_s1, mag_hi_s1, dmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.par     <= dmag_c <= W'(eps);
			side_s1.in_slab <= (origin >= box_lo) && (origin <= box_hi);
			side_s1.neg_lo  <= diff_lo[W] ^ dneg;
			side_s1.neg_hi  <= diff_hi[W] ^ dneg;
			mag_lo_s1       <= abs_lo[W-1:0];
			mag_hi_s1       <= abs_hi[W-1:0];
			dmag_s1         <= dmag_c;
		end
	end

	// dividers
	logic [W:0] quo_lo, quo_hi;
	logic       ovf_lo, ovf_hi;

	rbst_div #(.W(W), .F(F)) u_div_lo (
		.clk  (clk),
		.en   (en),
		.mag  (mag_lo_s1),
		.dmag (dmag_s1),
		.quo  (quo_lo),
		.ovf  (ovf_lo)
	);

	rbst_div #(.W(W), .F(F)) u_div_hi (
		.clk  (clk),
		.en   (en),
		.mag  (mag_hi_s1),
		.dmag (dmag_s1),
		.quo  (quo_hi),
		.ovf  (ovf_hi)
	);

	// sideband delay matching the divider depth
	logic  vld_d  [0:QB];
	side_t side_d [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= valid_s1;
			for (int i = 1; i <= QB; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s1;
			for (int i = 1; i <= QB; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// saturate and key
	logic         valid_s3;
	side_t        side_s3;
	logic [W-1:0] key_lo_s3, key_hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= vld_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3   <= side_d[QB];
			key_lo_s3 <= to_key(quo_lo, ovf_lo, side_d[QB].neg_lo);
			key_hi_s3 <= to_key(quo_hi, ovf_hi, side_d[QB].neg_hi);
		end
	end

	// order into near/far; a parallel axis leaves the interval open
	logic         valid_s4;
	logic         par_s4, inside_s4;
	logic [W-1:0] near_s4, far_s4;
	logic         lo_first;

	assign lo_first = key_lo_s3 < key_hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s4    <= side_s3.par;
			inside_s4 <= side_s3.in_slab;
			if (side_s3.par) begin
				near_s4 <= '0;
				far_s4  <= '1;
			end else begin
				near_s4 <= lo_first ? key_lo_s3 : key_hi_s3;
				far_s4  <= lo_first ? key_hi_s3 : key_lo_s3;
			end
		end
	end

	assign flags.valid   = valid_s4;
	assign flags.par     = par_s4;
	assign flags.in_slab = inside_s4;
	assign near_key      = near_s4;
	assign far_key       = far_s4;

endmodule
